FILE: sv/assert_macros.svh
// Assertion helpers; expect clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define RBSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RBSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define RBSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rbsh_pkg.sv
`default_nettype none
package rbsh_pkg;
  localparam int FRAC_BITS = 16;
  localparam int ORG_W     = 32;
  localparam int DIR_W     = 18;
  localparam int CELL_W    = 16;
  localparam int BOX_W     = 17;
  localparam int TEX_W     = 8;
  localparam int DIST_W    = 32;
  localparam int CFG_IDX_W = 3;
  // box bound: cell * ONE + offset, plus headroom for the far edge
  localparam int BND_W     = CELL_W + FRAC_BITS + 2;
  // magnitude of (bound - origin) stays below 2^33
  localparam int MAG_W     = 33;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int DEN_W     = DIR_W;
  localparam int T_W       = 64;
  localparam logic signed [T_W-1:0] T_UNB = 64'sh4000_0000_0000_0000;
  localparam int SLAB_LAT  = NUM_W + 2;
  localparam int SEG_STEPS = FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_TEX    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                  valid;
    logic                  miss;
    logic signed [T_W-1:0] tmin;
    logic signed [T_W-1:0] tmax;
  } slab_res_t;
endpackage
`default_nettype wire

FILE: sv/ray_box_slab_hit.sv
`default_nettype none
// 2D ray against an axis-aligned box inside a grid cell, slab method, Q16.16.
// Issue a ray by raising start; busy is always low, so a ray is taken on
// every cycle start is high. Each ray yields exactly one result, shown for
// a single cycle with out_valid high; the receiver cannot stall, so capture
// it then. Results leave in issue order. The latency is set by the two
// restoring dividers per axis (one quotient bit per stage, 49 stages) and
// the 16-stage divider for the face coordinate. A miss returns all fields
// zero. Write the box registers only with no ray in flight.
module ray_box_slab_hit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rbsh_pkg::ORG_W-1:0]     in_origin_x,
  input  logic signed [rbsh_pkg::ORG_W-1:0]     in_origin_y,
  input  logic signed [rbsh_pkg::DIR_W-1:0]     in_dir_x,
  input  logic signed [rbsh_pkg::DIR_W-1:0]     in_dir_y,
  input  logic        [rbsh_pkg::CELL_W-1:0]    in_cell_x,
  input  logic        [rbsh_pkg::CELL_W-1:0]    in_cell_y,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic        [rbsh_pkg::DIST_W-1:0]    out_distance,
  output logic        [rbsh_pkg::BOX_W-1:0]     out_segment_pos,
  output logic                                  out_shaded,
  output logic        [rbsh_pkg::TEX_W-1:0]     out_texture_out,
  input  logic                                  cfg_we,
  input  logic        [rbsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rbsh_pkg::BOX_W-1:0]     cfg_data
);
  import rbsh_pkg::*;
  `include "assert_macros.svh"

  localparam int PLO_W  = 25;
  localparam int PHI_W  = NUM_W - PLO_W;
  localparam int PROD_W = DIR_W + NUM_W + 1;
  localparam int H_W    = 54;
  localparam int D_W    = H_W + 1;
  localparam int Q_W    = SEG_STEPS;

  typedef struct packed {
    logic signed [ORG_W-1:0] ox;
    logic signed [ORG_W-1:0] oy;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
    logic        [BND_W-1:0] lox;
    logic        [BND_W-1:0] loy;
    logic        [BOX_W-1:0] w;
    logic        [BOX_W-1:0] h;
  } side_t;

  // configuration registers
  logic [BOX_W-1:0] box_left_r, box_top_r, box_width_r, box_height_r;
  logic [TEX_W-1:0] texture_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_width_r  <= BOX_W'(1 << FRAC_BITS);
      box_height_r <= BOX_W'(1 << FRAC_BITS);
      texture_id_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_LEFT:   box_left_r   <= cfg_data;
        REG_TOP:    box_top_r    <= cfg_data;
        REG_WIDTH:  box_width_r  <= cfg_data;
        REG_HEIGHT: box_height_r <= cfg_data;
        REG_TEX:    texture_id_r <= cfg_data[TEX_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign busy = 1'b0;

  // entry stage: capture the transaction and place the box in the cell
  logic  s0_v_r;
  side_t s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else        s0_v_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s0_r.ox  <= in_origin_x;
    s0_r.oy  <= in_origin_y;
    s0_r.dx  <= in_dir_x;
    s0_r.dy  <= in_dir_y;
    s0_r.lox <= {2'b00, in_cell_x, {FRAC_BITS{1'b0}}} + BND_W'(box_left_r);
    s0_r.loy <= {2'b00, in_cell_y, {FRAC_BITS{1'b0}}} + BND_W'(box_top_r);
    s0_r.w   <= box_width_r;
    s0_r.h   <= box_height_r;
  end

  // slab times per axis
  slab_res_t resx, resy;

  rbsh_slab u_slab_x (
    .clk(clk), .rst_n(rst_n), .in_valid(s0_v_r),
    .org(s0_r.ox), .dir(s0_r.dx), .lo(s0_r.lox), .size(s0_r.w), .res(resx)
  );

  rbsh_slab u_slab_y (
    .clk(clk), .rst_n(rst_n), .in_valid(s0_v_r),
    .org(s0_r.oy), .dir(s0_r.dy), .lo(s0_r.loy), .size(s0_r.h), .res(resy)
  );

  // hold the ray alongside the dividers
  side_t sd_r [0:SLAB_LAT-1];

  always_ff @(posedge clk) begin
    sd_r[0] <= s0_r;
    for (int i = 1; i < SLAB_LAT; i++) sd_r[i] <= sd_r[i-1];
  end

  // E1: combine slabs, pick the distance and the struck face
  side_t                   sd;
  logic                    e1_gt, e1_hit_nxt;
  logic signed [T_W-1:0]   t_ent, t_ext, t_sel;
  logic                    e1_v_r, e1_hit_r, e1_shaded_r;
  logic [DIST_W-1:0]       e1_dist_r;
  logic [NUM_W-1:0]        e1_t_r;
  logic signed [ORG_W-1:0] e1_fo_r;
  logic signed [DIR_W-1:0] e1_fd_r;
  logic [BND_W-1:0]        e1_flo_r;
  logic [BOX_W-1:0]        e1_fsz_r;

  always_comb begin
    sd         = sd_r[SLAB_LAT-1];
    e1_gt      = resx.tmin > resy.tmin;
    t_ent      = e1_gt ? resx.tmin : resy.tmin;
    t_ext      = (resx.tmax < resy.tmax) ? resx.tmax : resy.tmax;
    e1_hit_nxt = !resx.miss && !resy.miss && !(t_ent > t_ext) && !(t_ext < 0);
    // exit distance when the origin is already inside the box
    t_sel      = (t_ent >= 0) ? t_ent : t_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e1_v_r <= 1'b0;
    else        e1_v_r <= resx.valid;
  end

  always_ff @(posedge clk) begin
    e1_hit_r    <= e1_hit_nxt;
    e1_shaded_r <= !e1_gt;
    e1_dist_r   <= (t_sel > $signed({{(T_W-DIST_W){1'b0}}, {DIST_W{1'b1}}}))
                   ? {DIST_W{1'b1}} : t_sel[DIST_W-1:0];
    e1_t_r      <= t_sel[NUM_W-1:0];
    e1_fo_r     <= e1_gt ? sd.oy  : sd.ox;
    e1_fd_r     <= e1_gt ? sd.dy  : sd.dx;
    e1_flo_r    <= e1_gt ? sd.loy : sd.lox;
    e1_fsz_r    <= e1_gt ? sd.h   : sd.w;
  end

  // E2: dir * t as two partial products
  logic                            e2_v_r, e2_hit_r, e2_shaded_r;
  logic [DIST_W-1:0]               e2_dist_r;
  logic signed [DIR_W+PLO_W:0]     e2_plo_r;
  logic signed [DIR_W+PHI_W:0]     e2_phi_r;
  logic signed [ORG_W-1:0]         e2_fo_r;
  logic [BND_W-1:0]                e2_flo_r;
  logic [BOX_W-1:0]                e2_fsz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e2_v_r <= 1'b0;
    else        e2_v_r <= e1_v_r;
  end

  always_ff @(posedge clk) begin
    e2_hit_r    <= e1_hit_r;
    e2_shaded_r <= e1_shaded_r;
    e2_dist_r   <= e1_dist_r;
    e2_plo_r    <= e1_fd_r * $signed({1'b0, e1_t_r[PLO_W-1:0]});
    e2_phi_r    <= e1_fd_r * $signed({1'b0, e1_t_r[NUM_W-1:PLO_W]});
    e2_fo_r     <= e1_fo_r;
    e2_flo_r    <= e1_flo_r;
    e2_fsz_r    <= e1_fsz_r;
  end

  // E3: hit coordinate, origin plus floor(dir * t / ONE)
  logic signed [PROD_W-1:0] prod;
  logic                     e3_v_r, e3_hit_r, e3_shaded_r;
  logic [DIST_W-1:0]        e3_dist_r;
  logic signed [H_W-1:0]    e3_h_r;
  logic [BND_W-1:0]         e3_flo_r;
  logic [BOX_W-1:0]         e3_fsz_r;

  assign prod = (PROD_W'(e2_phi_r) <<< PLO_W) + PROD_W'(e2_plo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) e3_v_r <= 1'b0;
    else        e3_v_r <= e2_v_r;
  end

  always_ff @(posedge clk) begin
    e3_hit_r    <= e2_hit_r;
    e3_shaded_r <= e2_shaded_r;
    e3_dist_r   <= e2_dist_r;
    e3_h_r      <= H_W'(e2_fo_r) + H_W'($signed(prod[PROD_W-1:FRAC_BITS]));
    e3_flo_r    <= e2_flo_r;
    e3_fsz_r    <= e2_fsz_r;
  end

  // E4: offset along the face, clamp, seed the coordinate divider
  logic signed [D_W-1:0] d_off;
  logic                  e4_zero, e4_one;

  always_comb begin
    d_off   = D_W'(e3_h_r) - $signed({{(D_W-BND_W){1'b0}}, e3_flo_r});
    e4_zero = (e3_fsz_r == '0) || (d_off <= 0);
    e4_one  = (d_off >= $signed({{(D_W-BOX_W){1'b0}}, e3_fsz_r}));
  end

  logic              sg_v_r    [0:SEG_STEPS];
  logic              sg_hit_r  [0:SEG_STEPS];
  logic              sg_sh_r   [0:SEG_STEPS];
  logic [DIST_W-1:0] sg_dist_r [0:SEG_STEPS];
  logic              sg_zero_r [0:SEG_STEPS];
  logic              sg_one_r  [0:SEG_STEPS];
  logic [BOX_W-1:0]  sg_sz_r   [0:SEG_STEPS];
  logic [BOX_W-1:0]  sg_rem_r  [0:SEG_STEPS];
  logic [Q_W-1:0]    sg_q_r    [0:SEG_STEPS];

  logic              sg_v_nxt    [0:SEG_STEPS];
  logic [BOX_W-1:0]  sg_rem_nxt  [0:SEG_STEPS];
  logic [Q_W-1:0]    sg_q_nxt    [0:SEG_STEPS];

  always_comb begin
    logic [BOX_W:0] sh;
    logic           ge;
    sg_v_nxt[0]   = e3_v_r;
    sg_rem_nxt[0] = d_off[BOX_W-1:0];
    sg_q_nxt[0]   = '0;
    // remainder starts below the face size, so each step yields a fraction bit
    for (int k = 0; k < SEG_STEPS; k++) begin
      sh = {sg_rem_r[k], 1'b0};
      ge = (sh >= {1'b0, sg_sz_r[k]});
      sg_rem_nxt[k+1] = ge ? BOX_W'(sh - {1'b0, sg_sz_r[k]}) : sh[BOX_W-1:0];
      sg_q_nxt[k+1]   = {sg_q_r[k][Q_W-2:0], ge};
      sg_v_nxt[k+1]   = sg_v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SEG_STEPS; k++) sg_v_r[k] <= 1'b0;
    end else begin
      sg_v_r <= sg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sg_rem_r     <= sg_rem_nxt;
    sg_q_r       <= sg_q_nxt;
    sg_hit_r[0]  <= e3_hit_r;
    sg_sh_r[0]   <= e3_shaded_r;
    sg_dist_r[0] <= e3_dist_r;
    sg_zero_r[0] <= e4_zero;
    sg_one_r[0]  <= e4_one;
    sg_sz_r[0]   <= e3_fsz_r;
    for (int k = 1; k <= SEG_STEPS; k++) begin
      sg_hit_r[k]  <= sg_hit_r[k-1];
      sg_sh_r[k]   <= sg_sh_r[k-1];
      sg_dist_r[k] <= sg_dist_r[k-1];
      sg_zero_r[k] <= sg_zero_r[k-1];
      sg_one_r[k]  <= sg_one_r[k-1];
      sg_sz_r[k]   <= sg_sz_r[k-1];
    end
  end

  // output stage: clamp the coordinate, zero everything on a miss
  logic             out_valid_r, out_hit_r, out_shaded_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [BOX_W-1:0]  out_seg_r, seg_nxt;
  logic [TEX_W-1:0]  out_tex_r;
  logic              fin_hit;

  always_comb begin
    fin_hit = sg_hit_r[SEG_STEPS];
    if (sg_zero_r[SEG_STEPS])     seg_nxt = '0;
    else if (sg_one_r[SEG_STEPS]) seg_nxt = BOX_W'(1 << FRAC_BITS);
    else                          seg_nxt = {1'b0, sg_q_r[SEG_STEPS]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= sg_v_r[SEG_STEPS];
  end

  always_ff @(posedge clk) begin
    out_hit_r    <= fin_hit;
    out_dist_r   <= fin_hit ? sg_dist_r[SEG_STEPS] : '0;
    out_seg_r    <= fin_hit ? seg_nxt : '0;
    out_shaded_r <= fin_hit && sg_sh_r[SEG_STEPS];
    out_tex_r    <= fin_hit ? texture_id_r : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_distance    = out_dist_r;
  assign out_segment_pos = out_seg_r;
  assign out_shaded      = out_shaded_r;
  assign out_texture_out = out_tex_r;

  `RBSH_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, (out_distance == '0) && (out_segment_pos == '0) && !out_shaded && (out_texture_out == '0), "miss result carries data")
  `RBSH_ASSERT_IMP(a_seg_range, out_valid, out_segment_pos <= BOX_W'(1 << FRAC_BITS), "segment_pos above one")
  `RBSH_ASSERT_NEXT(a_seg_frac, sg_v_r[SEG_STEPS] && sg_hit_r[SEG_STEPS] && !sg_zero_r[SEG_STEPS] && !sg_one_r[SEG_STEPS], out_segment_pos < BOX_W'(1 << FRAC_BITS), "unclamped coordinate reached one")
endmodule
`default_nettype wire

FILE: sv/rbsh_slab.sv
`default_nettype none
module rbsh_slab (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [rbsh_pkg::ORG_W-1:0] org,
  input  logic signed [rbsh_pkg::DIR_W-1:0] dir,
  input  logic        [rbsh_pkg::BND_W-1:0] lo,
  input  logic        [rbsh_pkg::BOX_W-1:0] size,
  output rbsh_pkg::slab_res_t               res
);
  import rbsh_pkg::*;

  localparam int DW = BND_W + 2;

  logic signed [DW-1:0] lo_s, hi_s, org_s, d1, d2, m1, m2;

  logic             v_r   [0:NUM_W];
  logic [NUM_W-1:0] q1_r  [0:NUM_W];
  logic [NUM_W-1:0] q2_r  [0:NUM_W];
  logic [DEN_W-1:0] r1_r  [0:NUM_W];
  logic [DEN_W-1:0] r2_r  [0:NUM_W];
  logic [DEN_W-1:0] dm_r  [0:NUM_W];
  logic             s1_r  [0:NUM_W];
  logic             s2_r  [0:NUM_W];
  logic             dz_r  [0:NUM_W];
  logic             ms_r  [0:NUM_W];

  logic             v_nxt  [0:NUM_W];
  logic [NUM_W-1:0] q1_nxt [0:NUM_W];
  logic [NUM_W-1:0] q2_nxt [0:NUM_W];
  logic [DEN_W-1:0] r1_nxt [0:NUM_W];
  logic [DEN_W-1:0] r2_nxt [0:NUM_W];
  logic [DEN_W-1:0] dm_nxt [0:NUM_W];
  logic             s1_nxt [0:NUM_W];
  logic             s2_nxt [0:NUM_W];
  logic             dz_nxt [0:NUM_W];
  logic             ms_nxt [0:NUM_W];

  slab_res_t             res_nxt;
  logic                  res_v_r, res_miss_r;
  logic signed [T_W-1:0] res_tmin_r, res_tmax_r;

  always_comb begin
    logic [DEN_W:0] sh1, sh2;
    logic           ge1, ge2;
    // prepare numerators and divisor magnitude
    lo_s  = $signed({2'b00, lo});
    hi_s  = lo_s + $signed({{(DW-BOX_W){1'b0}}, size});
    org_s = DW'(org);
    d1    = lo_s - org_s;
    d2    = hi_s - org_s;
    m1    = d1[DW-1] ? -d1 : d1;
    m2    = d2[DW-1] ? -d2 : d2;
    v_nxt[0]  = in_valid;
    q1_nxt[0] = {m1[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    q2_nxt[0] = {m2[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    r1_nxt[0] = '0;
    r2_nxt[0] = '0;
    dm_nxt[0] = dir[DIR_W-1] ? DEN_W'(-dir) : DEN_W'(dir);
    s1_nxt[0] = d1[DW-1] ^ dir[DIR_W-1];
    s2_nxt[0] = d2[DW-1] ^ dir[DIR_W-1];
    dz_nxt[0] = (dir == '0);
    ms_nxt[0] = (dir == '0) && ((org_s < lo_s) || (org_s > hi_s));
    // one restoring quotient bit per stage
    for (int k = 0; k < NUM_W; k++) begin
      sh1 = {r1_r[k], q1_r[k][NUM_W-1]};
      sh2 = {r2_r[k], q2_r[k][NUM_W-1]};
      ge1 = (sh1 >= {1'b0, dm_r[k]});
      ge2 = (sh2 >= {1'b0, dm_r[k]});
      r1_nxt[k+1] = ge1 ? DEN_W'(sh1 - {1'b0, dm_r[k]}) : sh1[DEN_W-1:0];
      r2_nxt[k+1] = ge2 ? DEN_W'(sh2 - {1'b0, dm_r[k]}) : sh2[DEN_W-1:0];
      q1_nxt[k+1] = {q1_r[k][NUM_W-2:0], ge1};
      q2_nxt[k+1] = {q2_r[k][NUM_W-2:0], ge2};
      v_nxt[k+1]  = v_r[k];
      dm_nxt[k+1] = dm_r[k];
      s1_nxt[k+1] = s1_r[k];
      s2_nxt[k+1] = s2_r[k];
      dz_nxt[k+1] = dz_r[k];
      ms_nxt[k+1] = ms_r[k];
    end
  end

  always_comb begin
    logic signed [T_W-1:0] t1, t2;
    t1 = $signed({{(T_W-NUM_W){1'b0}}, q1_r[NUM_W]});
    t2 = $signed({{(T_W-NUM_W){1'b0}}, q2_r[NUM_W]});
    if (s1_r[NUM_W]) t1 = -t1;
    if (s2_r[NUM_W]) t2 = -t2;
    res_nxt.valid = v_r[NUM_W];
    res_nxt.miss  = ms_r[NUM_W];
    if (dz_r[NUM_W]) begin
      res_nxt.tmin = -T_UNB;
      res_nxt.tmax = T_UNB;
    end else begin
      res_nxt.tmin = (t1 < t2) ? t1 : t2;
      res_nxt.tmax = (t1 < t2) ? t2 : t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NUM_W; k++) v_r[k] <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      v_r     <= v_nxt;
      res_v_r <= res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    q1_r <= q1_nxt;
    q2_r <= q2_nxt;
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    dm_r <= dm_nxt;
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    dz_r <= dz_nxt;
    ms_r <= ms_nxt;
    res_miss_r <= res_nxt.miss;
    res_tmin_r <= res_nxt.tmin;
    res_tmax_r <= res_nxt.tmax;
  end

  assign res = {res_v_r, res_miss_r, res_tmin_r, res_tmax_r};
endmodule
`default_nettype wire

FILE: tb/sv/ray_box_slab_hit_checker.sv
`timescale 1ns / 100ps
module ray_box_slab_hit_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [rbsh_pkg::ORG_W-1:0]     in_origin_x,
  input  logic signed [rbsh_pkg::ORG_W-1:0]     in_origin_y,
  input  logic signed [rbsh_pkg::DIR_W-1:0]     in_dir_x,
  input  logic signed [rbsh_pkg::DIR_W-1:0]     in_dir_y,
  input  logic        [rbsh_pkg::CELL_W-1:0]    in_cell_x,
  input  logic        [rbsh_pkg::CELL_W-1:0]    in_cell_y,
  input  logic                                  out_valid,
  input  logic                                  out_hit,
  input  logic        [rbsh_pkg::DIST_W-1:0]    out_distance,
  input  logic        [rbsh_pkg::BOX_W-1:0]     out_segment_pos,
  input  logic                                  out_shaded,
  input  logic        [rbsh_pkg::TEX_W-1:0]     out_texture_out,
  input  logic                                  cfg_we,
  input  logic        [rbsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [rbsh_pkg::BOX_W-1:0]     cfg_data,
  output int                                    rays_in_flight,
  output int                                    fail_count
);
  import rbsh_pkg::*;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [BOX_W-1:0]  segment_pos;
    logic              shaded;
    logic [TEX_W-1:0]  texture;
  } hit_rec_t;

  logic [BOX_W-1:0] box_left_q, box_top_q, box_width_q, box_height_q;
  logic [TEX_W-1:0] texture_q;
  hit_rec_t         pending_hits[$];

  function automatic bit slab_interval(longint org, longint dir, longint lo, longint hi,
                                       output longint tmin, output longint tmax);
    longint t1, t2;
    tmin = 0;
    tmax = 0;
    if (dir == 0) begin
      if (org < lo || org > hi) return 0;
      tmin = -T_UNB;
      tmax = T_UNB;
      return 1;
    end
    t1 = ((lo - org) * ONE_Q) / dir;
    t2 = ((hi - org) * ONE_Q) / dir;
    tmin = (t1 < t2) ? t1 : t2;
    tmax = (t1 < t2) ? t2 : t1;
    return 1;
  endfunction

  function automatic logic [BOX_W-1:0] face_coord(longint org, longint dir, longint t,
                                                  longint lo, longint size);
    longint h, d;
    h = (dir == 0) ? org : org + ((dir * t) >>> FRAC_BITS);
    d = h - lo;
    if (size <= 0 || d <= 0) return '0;
    if (d >= size) return BOX_W'(ONE_Q);
    return BOX_W'((d * ONE_Q) / size);
  endfunction

  function automatic hit_rec_t predict_hit(longint ox, longint oy, longint dx, longint dy,
                                           longint cx, longint cy);
    hit_rec_t r;
    longint   minx, miny, maxx, maxy, tminx, tmaxx, tminy, tmaxy, tenter, texit, t;
    r = '0;
    minx = cx * ONE_Q + longint'(box_left_q);
    miny = cy * ONE_Q + longint'(box_top_q);
    maxx = minx + longint'(box_width_q);
    maxy = miny + longint'(box_height_q);
    if (!slab_interval(ox, dx, minx, maxx, tminx, tmaxx)) return r;
    if (!slab_interval(oy, dy, miny, maxy, tminy, tmaxy)) return r;
    tenter = (tminx > tminy) ? tminx : tminy;
    texit  = (tmaxx < tmaxy) ? tmaxx : tmaxy;
    if (tenter > texit || texit < 0) return r;
    // take the exit point when the origin sits inside the box
    t = (tenter >= 0) ? tenter : texit;
    if (tminx > tminy)
      r.segment_pos = face_coord(oy, dy, t, miny, longint'(box_height_q));
    else
      r.segment_pos = face_coord(ox, dx, t, minx, longint'(box_width_q));
    r.hit      = 1'b1;
    r.distance = (t > longint'(32'hFFFF_FFFF)) ? '1 : DIST_W'(t);
    r.shaded   = (tminx <= tminy);
    r.texture  = texture_q;
    return r;
  endfunction

  always @(posedge clk) begin
    hit_rec_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      box_left_q   <= '0;
      box_top_q    <= '0;
      box_width_q  <= BOX_W'(ONE_Q);
      box_height_q <= BOX_W'(ONE_Q);
      texture_q    <= '0;
      pending_hits.delete();
      fail_count   <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_LEFT:   box_left_q   <= cfg_data;
          REG_TOP:    box_top_q    <= cfg_data;
          REG_WIDTH:  box_width_q  <= cfg_data;
          REG_HEIGHT: box_height_q <= cfg_data;
          REG_TEX:    texture_q    <= cfg_data[TEX_W-1:0];
          default:    ;
        endcase
      end
      if (start && !busy)
        pending_hits.push_back(predict_hit(in_origin_x, in_origin_y, in_dir_x, in_dir_y,
                                           longint'(in_cell_x), longint'(in_cell_y)));
      if (out_valid) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          want = pending_hits.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            errs++;
          end
          if (out_distance !== want.distance) begin
            $error("distance: expected %0h, got %0h", want.distance, out_distance);
            errs++;
          end
          if (out_segment_pos !== want.segment_pos) begin
            $error("segment_pos: expected %0h, got %0h", want.segment_pos, out_segment_pos);
            errs++;
          end
          if (out_shaded !== want.shaded) begin
            $error("shaded: expected %0d, got %0d", want.shaded, out_shaded);
            errs++;
          end
          if (out_texture_out !== want.texture) begin
            $error("texture_out: expected %0h, got %0h", want.texture, out_texture_out);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

  assign rays_in_flight = pending_hits.size();
endmodule

FILE: tb/sv/tb_ray_box_slab_hit.sv
`timescale 1ns / 100ps
module tb_ray_box_slab_hit;
  import rbsh_pkg::*;

  // an index past the register list; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd7;
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  // settle time after the checker has seen every result
  localparam int DRAIN_CYCLES = 100;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [ORG_W-1:0]  in_origin_x, in_origin_y;
  logic signed [DIR_W-1:0]  in_dir_x, in_dir_y;
  logic        [CELL_W-1:0] in_cell_x, in_cell_y;
  logic                     out_valid, out_hit, out_shaded;
  logic        [DIST_W-1:0] out_distance;
  logic        [BOX_W-1:0]  out_segment_pos;
  logic        [TEX_W-1:0]  out_texture_out;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic        [BOX_W-1:0]  cfg_data;
  int                       rays_in_flight;
  int                       fail_count;
  int                       idle_pct;

  ray_box_slab_hit i_dut (.*);

  ray_box_slab_hit_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block stops answering
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one ray; hold it until the block takes it, then leave start high
  // so that the next ray or an idle cycle replaces it at the following edge.
  task automatic send_ray(logic [ORG_W-1:0] ox, logic [ORG_W-1:0] oy,
                          logic [DIR_W-1:0] dx, logic [DIR_W-1:0] dy,
                          logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_dir_x    <= dx;
    in_dir_y    <= dy;
    in_cell_x   <= cx;
    in_cell_y   <= cy;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drain the pipeline before touching a box register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (rays_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_box(logic [BOX_W-1:0] left, logic [BOX_W-1:0] top,
                         logic [BOX_W-1:0] wid, logic [BOX_W-1:0] hgt, logic [TEX_W-1:0] tex);
    write_reg(REG_LEFT, left);
    write_reg(REG_TOP, top);
    write_reg(REG_WIDTH, wid);
    write_reg(REG_HEIGHT, hgt);
    write_reg(REG_TEX, BOX_W'(tex));
  endtask

  // Mostly rays aimed so that they pass through a point in or just past the cell
  // at an integer distance, some of them axis-parallel; the rest are raw noise.
  task automatic random_ray();
    longint tx, ty, s, dx, dy;
    logic [CELL_W-1:0] cx, cy;
    int kind;
    kind = $urandom_range(99);
    if (kind < 20) begin
      send_ray($urandom, $urandom, DIR_W'($urandom), DIR_W'($urandom),
               CELL_W'($urandom), CELL_W'($urandom));
      return;
    end
    cx = ($urandom_range(3) == 0) ? CELL_W'($urandom) : CELL_W'($urandom_range(32767));
    cy = ($urandom_range(3) == 0) ? CELL_W'($urandom) : CELL_W'($urandom_range(32767));
    tx = longint'(cx) * ONE_Q + $urandom_range(70000);
    ty = longint'(cy) * ONE_Q + $urandom_range(70000);
    dx = longint'(signed'(DIR_W'($urandom)));
    dy = longint'(signed'(DIR_W'($urandom)));
    if (kind < 28) dx = 0;
    else if (kind < 36) dy = 0;
    else if (kind < 44) begin
      dx = dx >>> $urandom_range(16);
      dy = dy >>> $urandom_range(16);
    end
    s = (kind % 5 == 0) ? longint'($urandom_range(40000)) : longint'($urandom_range(8));
    send_ray(ORG_W'(tx - dx * s), ORG_W'(ty - dy * s), DIR_W'(dx), DIR_W'(dy), cx, cy);
  endtask

  initial begin
    int seg;
    start       = 1'b0;
    in_origin_x = '0;
    in_origin_y = '0;
    in_dir_x    = '0;
    in_dir_y    = '0;
    in_cell_x   = '0;
    in_cell_y   = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_pct    = 0;
    rst_n       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset box: a full cell, texture 0
    send_ray(32'h0000_8000, 32'h0000_8000, 18'h0_0000, 18'h0_0000, 16'd0, 16'd0);
    send_ray(32'h0001_8000, 32'h0000_8000, 18'h0_0000, 18'h1_0000, 16'd0, 16'd0);
    send_ray(32'hFFFF_0000, 32'h0000_8000, 18'h1_0000, 18'h0_0000, 16'd0, 16'd0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'h2_0000, 18'h2_0000, 16'hFFFF, 16'hFFFF);
    send_ray(32'h8000_0000, 32'h8000_0000, 18'h1_FFFF, 18'h1_FFFF, 16'hFFFF, 16'hFFFF);
    send_ray(32'h8000_0000, 32'h0000_4000, 18'h0_0001, 18'h0_0000, 16'd0, 16'd0);
    send_ray(32'h0000_8000, 32'h0005_0000, 18'h0_0000, 18'h2_0000, 16'd0, 16'd0);
    send_ray(32'h0000_0000, 32'h0000_0000, 18'h1_0000, 18'h1_0000, 16'd0, 16'd0);
    send_ray(32'h0000_8000, 32'hFFFF_8000, 18'h0_4000, 18'h0_8000, 16'd0, 16'd0);

    // texture extreme, box of smallest size, then a box past its range
    set_box(17'h1_0000, 17'h1_0000, 17'd1, 17'd1, 8'hFF);
    write_reg(IDX_SPARE, 17'h1_FFFF);
    send_ray(32'h0000_0000, 32'h0000_0000, 18'h1_0000, 18'h1_0000, 16'd0, 16'd0);
    send_ray(32'h0001_0000, 32'h0000_0000, 18'h0_0000, 18'h1_0000, 16'd0, 16'd0);
    send_ray(32'h0001_0000, 32'h0001_0000, 18'h0_0000, 18'h0_0000, 16'd0, 16'd0);
    send_ray(32'h8000_0000, 32'h8000_0000, 18'h0_0001, 18'h0_0001, 16'd0, 16'd0);
    set_box(17'h1_FFFF, 17'h0_0000, 17'd0, 17'h1_FFFF, 8'h00);
    send_ray(32'h0000_0000, 32'h0001_0000, 18'h1_0000, 18'h0_0000, 16'd0, 16'd0);
    send_ray(32'h0001_FFFF, 32'h0000_0000, 18'h0_0000, 18'h1_0000, 16'd0, 16'd0);
    send_ray(32'h0002_0000, 32'h0000_8000, 18'h3_0000, 18'h0_1000, 16'd0, 16'd0);

    // random part: twelve stretches, the box changing between them
    for (seg = 0; seg < 12; seg++) begin
      case (seg % 4)
        0: set_box(17'd0, 17'd0, 17'h1_0000, 17'h1_0000, TEX_W'($urandom));
        1: set_box(17'h1_0000, 17'h1_0000, 17'd1, 17'd1, 8'hFF);
        2: set_box(17'($urandom_range(65536)), 17'($urandom_range(65536)),
                   17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65536)),
                   TEX_W'($urandom));
        default: set_box(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                         TEX_W'($urandom));
      endcase
      idle_pct = (seg < 4) ? 38 : (seg < 8) ? 84 : 0;
      repeat (145) random_ray();
    end

    start <= 1'b0;
    @(posedge clk);
    while (rays_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
